[design/vlts_pkg.sv]
// Shared constants and types of the video line table scroller.
package vlts_pkg;

    // defaults for the top-level parameters
    localparam int TEXT_LINES_DEF    = 15;
    localparam int ROWS_PER_LINE_DEF = 8;
    localparam int TEXT_COLUMNS_DEF  = 26;
    localparam int CHAR_WIDTH_DEF    = 6;
    localparam int TOTAL_ROWS_DEF    = 120;

    localparam int PAGE_W   = 8;
    localparam int SHIFT_W  = 8;
    localparam int SPAN_W   = 5;   // window span, at most 31 from the 5-bit end line
    localparam int ADDR_W   = 16;

    localparam logic [PAGE_W-1:0] BASE_PAGE_RESET = 8'd8;

    typedef enum logic [1:0] {
        CMD_RESET  = 2'd0,
        CMD_SCROLL = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_READ   = 2'd3
    } vlts_cmd_t;

    // request to the remainder unit
    typedef struct packed {
        logic               start;
        logic [SHIFT_W-1:0] shift;
        logic [SPAN_W-1:0]  span;
    } vlts_mod_req_t;

    // answer of the remainder unit
    typedef struct packed {
        logic              done;
        logic [SPAN_W-1:0] rem;
    } vlts_mod_res_t;

endpackage

[design/vlts_ram.sv]
// Generic simple dual-port RAM with registered read.
module vlts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/vlts_mod.sv]
// Iterative signed remainder of the scroll amount by the window span.
module vlts_mod (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  vlts_pkg::vlts_mod_req_t req,
    output vlts_pkg::vlts_mod_res_t res
);

    localparam int CNT_W = $clog2(vlts_pkg::SHIFT_W);

    logic                        busy_reg;
    logic                        done_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [vlts_pkg::SHIFT_W-1:0] mag_reg;
    logic                        neg_reg;
    logic [vlts_pkg::SPAN_W-1:0] span_reg;
    logic [vlts_pkg::SPAN_W-1:0] rem_reg;
    logic [vlts_pkg::SPAN_W:0]   trial;
    logic [vlts_pkg::SPAN_W-1:0] rem_next;

    // one restoring step per cycle, magnitude bits from the top
    always_comb begin
        trial = {rem_reg, mag_reg[vlts_pkg::SHIFT_W-1]};
        if (trial >= {1'b0, span_reg}) begin
            rem_next = vlts_pkg::SPAN_W'(trial - {1'b0, span_reg});
        end else begin
            rem_next = trial[vlts_pkg::SPAN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                neg_reg  <= req.shift[vlts_pkg::SHIFT_W-1];
                mag_reg  <= req.shift[vlts_pkg::SHIFT_W-1] ? (~req.shift + 1'b1) : req.shift;
                span_reg <= req.span;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                mag_reg <= {mag_reg[vlts_pkg::SHIFT_W-2:0], 1'b0};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(vlts_pkg::SHIFT_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // negative amounts fold back into [0, span)
    assign res.done = done_reg;
    assign res.rem  = (neg_reg && (rem_reg != '0)) ? (span_reg - rem_reg) : rem_reg;

    a_rem_below_span: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (res.rem < span_reg))
        else $error("remainder not below span");

    a_done_ends_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("remainder unit busy after done");

    a_start_gives_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |=> busy_reg)
        else $error("remainder unit did not start");

endmodule

[design/video_line_table_scroller_unit.sv]
// Video line table scroller: row table, line scratch table and command sequencer.
// A table reset refills the row table; query and read go straight to the result word;
// a scroll runs the remainder unit (skipped for an empty window), gathers the page of each
// of the TEXT_LINES lines, turns around and rewrites min(TEXT_LINES*ROWS_PER_LINE, TOTAL_ROWS) rows.
// One command at a time; a result word waiting on m_tready holds back the next command.
// After aresetn the block fills the row table (s_tready low).
// base_page resets to 8 and may be written at any time through cfg_we.
module video_line_table_scroller_unit #(
    parameter int TEXT_LINES    = vlts_pkg::TEXT_LINES_DEF,
    parameter int ROWS_PER_LINE = vlts_pkg::ROWS_PER_LINE_DEF,
    parameter int TEXT_COLUMNS  = vlts_pkg::TEXT_COLUMNS_DEF,
    parameter int CHAR_WIDTH    = vlts_pkg::CHAR_WIDTH_DEF,
    parameter int TOTAL_ROWS    = vlts_pkg::TOTAL_ROWS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,      // base_page
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,        // first_line, end_line, shift, column, line, row
    input  logic [1:0]  s_tuser,        // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata         // address, in_range, row_page
);

    localparam int ROW_AW    = (TOTAL_ROWS > 1) ? $clog2(TOTAL_ROWS) : 1;
    localparam int LIDX_W    = (TEXT_LINES > 1) ? $clog2(TEXT_LINES) : 1;
    localparam int KW        = (ROWS_PER_LINE > 1) ? $clog2(ROWS_PER_LINE) : 1;
    localparam int SPAN_ROWS = TEXT_LINES * ROWS_PER_LINE;
    localparam int ROWS_LAST = ((SPAN_ROWS < TOTAL_ROWS) ? SPAN_ROWS : TOTAL_ROWS) - 1;
    localparam int PW        = vlts_pkg::PAGE_W;
    localparam int SW        = vlts_pkg::SPAN_W;

    typedef enum logic [2:0] {
        ST_FILL, ST_IDLE, ST_MOD, ST_LINES, ST_LINES_END, ST_ROWS, ST_ROWS_END, ST_RESULT
    } state_t;

    state_t state_reg;

    logic [PW-1:0]     base_page_reg;
    logic [PW-1:0]     fill_base_reg;
    logic              init_reg;
    logic [ROW_AW-1:0] fill_cnt_reg;

    vlts_pkg::vlts_cmd_t cmd_reg;
    logic              page_ok_reg;
    logic              q_ok_reg;
    logic [5:0]        col_reg;

    logic [SW-1:0]     first_reg;
    logic [SW-1:0]     end_reg;
    logic [SW-1:0]     span_reg;
    logic [SW-1:0]     r_reg;
    logic [LIDX_W-1:0] n_reg;

    logic              p1_pend_reg;
    logic [LIDX_W-1:0] p1_line_reg;
    logic              p1_zero_reg;

    logic [ROW_AW-1:0] rr_reg;
    logic [LIDX_W-1:0] n2_reg;
    logic [KW-1:0]     k_reg;
    logic              p2_pend_reg;
    logic [ROW_AW-1:0] p2_row_reg;
    logic [KW-1:0]     p2_k_reg;

    logic              m_valid_reg;
    logic [31:0]       m_data_reg;

    // input word fields
    vlts_pkg::vlts_cmd_t cmd_in;
    logic [4:0]        first_in;
    logic [4:0]        end_in;
    logic [7:0]        shift_in;
    logic [6:0]        x_in;
    logic [5:0]        y_in;
    logic [6:0]        row_in;

    logic              accept;
    logic [SW-1:0]     first_c_in;
    logic [SW-1:0]     end_c_in;
    logic              win_in;
    int                q_row_int;
    logic              q_ok_in;
    logic              q_page_ok_in;
    logic              rd_ok_in;

    logic [SW-1:0]     n_ext;
    logic              in_win;
    logic [SW-1:0]     src;
    int                src_row_int;
    logic              src_ok;

    logic              row_we;
    logic [ROW_AW-1:0] row_waddr;
    logic [PW-1:0]     row_wdata;
    logic              row_re;
    logic [ROW_AW-1:0] row_raddr;
    logic [PW-1:0]     row_rdata;
    logic              line_re;
    logic [PW-1:0]     line_rdata;
    logic [PW-1:0]     line_wdata;

    vlts_pkg::vlts_mod_req_t mod_req;
    vlts_pkg::vlts_mod_res_t mod_res;

    logic [PW-1:0]     res_page;
    logic [15:0]       res_address;
    logic [31:0]       res_word;

    assign cmd_in   = vlts_pkg::vlts_cmd_t'(s_tuser);
    assign first_in = s_tdata[4:0];
    assign end_in   = s_tdata[9:5];
    assign shift_in = s_tdata[17:10];
    assign x_in     = s_tdata[24:18];
    assign y_in     = s_tdata[30:25];
    assign row_in   = s_tdata[37:31];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // window clamp and query and read range checks
    always_comb begin
        first_c_in   = first_in[4] ? '0 : first_in;
        end_c_in     = (int'(end_in) > TEXT_LINES) ? SW'(TEXT_LINES) : end_in;
        win_in       = first_c_in < end_c_in;
        q_row_int    = int'(y_in[4:0]) * ROWS_PER_LINE;
        q_ok_in      = !y_in[5] && (int'(y_in[4:0]) < TEXT_LINES) &&
                       !x_in[6] && (int'(x_in[5:0]) < TEXT_COLUMNS);
        q_page_ok_in = q_row_int < TOTAL_ROWS;
        rd_ok_in     = int'(row_in) < TOTAL_ROWS;
    end

    // source line of the line being gathered
    always_comb begin
        n_ext       = SW'(n_reg);
        in_win      = (n_ext >= first_reg) && (n_ext < end_reg);
        src         = in_win ? SW'(first_reg + r_reg) : n_ext;
        src_row_int = int'(src) * ROWS_PER_LINE;
        src_ok      = src_row_int < TOTAL_ROWS;
    end

    assign mod_req.start = accept && (cmd_in == vlts_pkg::CMD_SCROLL) && win_in;
    assign mod_req.shift = shift_in;
    assign mod_req.span  = end_c_in - first_c_in;

    vlts_mod u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mod_req),
        .res     (mod_res)
    );

    // row table ports
    always_comb begin
        row_re    = 1'b0;
        row_raddr = '0;
        if (accept && (cmd_in == vlts_pkg::CMD_QUERY) && q_ok_in && q_page_ok_in) begin
            row_re    = 1'b1;
            row_raddr = ROW_AW'(q_row_int);
        end else if (accept && (cmd_in == vlts_pkg::CMD_READ) && rd_ok_in) begin
            row_re    = 1'b1;
            row_raddr = ROW_AW'(row_in);
        end else if ((state_reg == ST_LINES) && src_ok) begin
            row_re    = 1'b1;
            row_raddr = ROW_AW'(src_row_int);
        end
        if (state_reg == ST_FILL) begin
            row_we    = 1'b1;
            row_waddr = fill_cnt_reg;
            row_wdata = fill_base_reg + PW'(fill_cnt_reg);
        end else begin
            row_we    = p2_pend_reg;
            row_waddr = p2_row_reg;
            row_wdata = line_rdata + PW'(p2_k_reg);
        end
    end

    vlts_ram #(
        .WIDTH (PW),
        .DEPTH (TOTAL_ROWS)
    ) u_row_ram (
        .clk   (aclk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .re    (row_re),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    assign line_re    = (state_reg == ST_ROWS);
    assign line_wdata = p1_zero_reg ? '0 : row_rdata;

    vlts_ram #(
        .WIDTH (PW),
        .DEPTH (TEXT_LINES)
    ) u_line_ram (
        .clk   (aclk),
        .we    (p1_pend_reg),
        .waddr (p1_line_reg),
        .wdata (line_wdata),
        .re    (line_re),
        .raddr (n2_reg),
        .rdata (line_rdata)
    );

    // result word
    always_comb begin
        res_page    = page_ok_reg ? row_rdata : '0;
        res_address = {res_page, 8'h00} + 16'(CHAR_WIDTH * int'(col_reg));
        res_word    = '0;
        case (cmd_reg)
            vlts_pkg::CMD_QUERY: begin
                res_word[15:0] = q_ok_reg ? res_address : '0;
                res_word[16]   = q_ok_reg;
            end
            vlts_pkg::CMD_READ: begin
                res_word[24:17] = res_page;
            end
            default: begin
                res_word = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_FILL;
            base_page_reg <= vlts_pkg::BASE_PAGE_RESET;
            fill_base_reg <= vlts_pkg::BASE_PAGE_RESET;
            init_reg      <= 1'b1;
            fill_cnt_reg  <= '0;
            p1_pend_reg   <= 1'b0;
            p2_pend_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                base_page_reg <= cfg_wdata;
            end
            p1_pend_reg <= 1'b0;
            p2_pend_reg <= 1'b0;
            if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_FILL: begin
                    fill_cnt_reg <= fill_cnt_reg + 1'b1;
                    if (fill_cnt_reg == ROW_AW'(TOTAL_ROWS - 1)) begin
                        state_reg <= init_reg ? ST_IDLE : ST_RESULT;
                        init_reg  <= 1'b0;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        cmd_reg   <= cmd_in;
                        q_ok_reg  <= q_ok_in;
                        col_reg   <= x_in[5:0];
                        first_reg <= first_c_in;
                        end_reg   <= end_c_in;
                        span_reg  <= end_c_in - first_c_in;
                        n_reg     <= '0;
                        page_ok_reg <= (cmd_in == vlts_pkg::CMD_READ) ? rd_ok_in :
                                       (q_ok_in && q_page_ok_in);
                        unique case (cmd_in)
                            vlts_pkg::CMD_RESET: begin
                                fill_base_reg <= base_page_reg;
                                fill_cnt_reg  <= '0;
                                state_reg     <= ST_FILL;
                            end
                            vlts_pkg::CMD_SCROLL: begin
                                state_reg <= win_in ? ST_MOD : ST_LINES;
                            end
                            default: begin
                                state_reg <= ST_RESULT;
                            end
                        endcase
                    end
                end
                ST_MOD: begin
                    if (mod_res.done) begin
                        r_reg     <= mod_res.rem;
                        state_reg <= ST_LINES;
                    end
                end
                ST_LINES: begin
                    p1_pend_reg <= 1'b1;
                    p1_line_reg <= n_reg;
                    p1_zero_reg <= !src_ok;
                    if (in_win) begin
                        r_reg <= (SW'(r_reg + 1'b1) == span_reg) ? '0 : SW'(r_reg + 1'b1);
                    end
                    n_reg <= n_reg + 1'b1;
                    if (n_reg == LIDX_W'(TEXT_LINES - 1)) begin
                        state_reg <= ST_LINES_END;
                    end
                end
                ST_LINES_END: begin
                    rr_reg    <= '0;
                    n2_reg    <= '0;
                    k_reg     <= '0;
                    state_reg <= ST_ROWS;
                end
                ST_ROWS: begin
                    p2_pend_reg <= 1'b1;
                    p2_row_reg  <= rr_reg;
                    p2_k_reg    <= k_reg;
                    rr_reg      <= rr_reg + 1'b1;
                    if (k_reg == KW'(ROWS_PER_LINE - 1)) begin
                        k_reg  <= '0;
                        n2_reg <= n2_reg + 1'b1;
                    end else begin
                        k_reg <= k_reg + 1'b1;
                    end
                    if (rr_reg == ROW_AW'(ROWS_LAST)) begin
                        state_reg <= ST_ROWS_END;
                    end
                end
                ST_ROWS_END: begin
                    state_reg <= ST_RESULT;
                end
                ST_RESULT: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= res_word;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_idle_no_row_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !row_we)
        else $error("row table written while idle");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg != ST_IDLE))
        else $error("word accepted without leaving idle");

    a_phases_apart: assert property (@(posedge aclk) disable iff (!aresetn)
        !(p1_pend_reg && p2_pend_reg))
        else $error("line gather and row rewrite overlap");

    a_result_after_rows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROWS_END) |=> (state_reg == ST_RESULT) && !p2_pend_reg)
        else $error("row rewrite still pending at result");

endmodule

[tb/sv/video_line_table_scroller_checker.sv]
// Checker for the video line table scroller: mirrors the row table and compares every result word.
module video_line_table_scroller_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,      // base_page
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,        // first_line, end_line, shift, column, line, row
    input  logic [1:0]  s_tuser,        // cmd
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,        // address, in_range, row_page
    output int          error_count,
    output int          result_count,
    output int          open_count
);
    import vlts_pkg::*;

    localparam int LINES   = TEXT_LINES_DEF;
    localparam int ROWS    = ROWS_PER_LINE_DEF;
    localparam int COLUMNS = TEXT_COLUMNS_DEF;
    localparam int CHAR_W  = CHAR_WIDTH_DEF;
    localparam int TOTAL   = TOTAL_ROWS_DEF;

    typedef struct {
        logic [15:0] address;
        logic        in_range;
        logic [7:0]  row_page;
    } answer_t;

    logic [7:0] base_page;
    logic [7:0] row_pages [TOTAL];
    answer_t    pending_answers [$];

    function automatic logic [7:0] page_of_line(int n);
        int r;
        r = n * ROWS;
        if (r < 0 || r >= TOTAL)
            return 8'd0;
        return row_pages[r];
    endfunction

    task automatic fill_rows();
        for (int i = 0; i < TOTAL; i++)
            row_pages[i] = base_page + 8'(i);
    endtask

    task automatic scroll_window(int first, int last, int shift);
        logic [7:0] moved [LINES];
        int src;
        int span;
        int r;
        if (first < 0)
            first = 0;
        if (last > LINES)
            last = LINES;
        // all line pages come from the old table before any row changes
        for (int n = 0; n < LINES; n++) begin
            src = n;
            if (n >= first && n < last) begin
                span = last - first;
                r = (n - first + shift) % span;
                if (r < 0)
                    r += span;
                src = first + r;
            end
            moved[n] = page_of_line(src);
        end
        for (int n = 0; n < LINES; n++) begin
            for (int k = 0; k < ROWS; k++) begin
                r = n * ROWS + k;
                if (r < TOTAL)
                    row_pages[r] = moved[n] + 8'(k);
            end
        end
    endtask

    task automatic run_command(input vlts_cmd_t cmd, input logic [39:0] d, output answer_t ans);
        int x;
        int y;
        int r;
        logic [31:0] a;
        ans.address  = '0;
        ans.in_range = 1'b0;
        ans.row_page = '0;
        case (cmd)
            CMD_RESET: begin
                fill_rows();
            end
            CMD_SCROLL: begin
                scroll_window($signed(d[4:0]), int'(d[9:5]), $signed(d[17:10]));
            end
            CMD_QUERY: begin
                x = $signed(d[24:18]);
                y = $signed(d[30:25]);
                if (y >= 0 && y < LINES && x >= 0 && x < COLUMNS) begin
                    a = (32'(page_of_line(y)) << 8) + 32'(CHAR_W * x);
                    ans.address  = a[15:0];
                    ans.in_range = 1'b1;
                end
            end
            default: begin
                r = int'(d[37:31]);
                if (r < TOTAL)
                    ans.row_page = row_pages[r];
            end
        endcase
    endtask

    always @(posedge aclk) begin
        answer_t want;
        answer_t got;
        int errs;
        if (!aresetn) begin
            base_page = BASE_PAGE_RESET;
            fill_rows();
            pending_answers.delete();
            error_count  <= 0;
            result_count <= 0;
            open_count   <= 0;
        end else begin
            errs = 0;
            if (cfg_we)
                base_page = cfg_wdata;
            if (s_tvalid && s_tready) begin
                run_command(vlts_cmd_t'(s_tuser), s_tdata, want);
                pending_answers.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got.address  = m_tdata[15:0];
                got.in_range = m_tdata[16];
                got.row_page = m_tdata[24:17];
                if (pending_answers.size() == 0) begin
                    $error("unexpected result word: address %0h in_range %0b row_page %0h",
                           got.address, got.in_range, got.row_page);
                    errs++;
                end else begin
                    want = pending_answers.pop_front();
                    if (got.address !== want.address) begin
                        $error("address: expected %0h, got %0h", want.address, got.address);
                        errs++;
                    end
                    if (got.in_range !== want.in_range) begin
                        $error("in_range: expected %0b, got %0b", want.in_range, got.in_range);
                        errs++;
                    end
                    if (got.row_page !== want.row_page) begin
                        $error("row_page: expected %0h, got %0h", want.row_page, got.row_page);
                        errs++;
                    end
                end
                result_count <= result_count + 1;
            end
            open_count  <= pending_answers.size();
            error_count <= error_count + errs;
        end
    end

endmodule

[tb/sv/video_line_table_scroller_unit_test.sv]
// Testbench top for the video line table scroller: stimulus, receiver stalls and verdict.
module video_line_table_scroller_unit_test;
    import vlts_pkg::*;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [7:0]  cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic [39:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tready  = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [31:0] m_tdata;

    int error_count;
    int result_count;
    int open_count;
    int words_sent = 0;
    int burst_left = 0;

    // receiver state
    int seen_words = 0;
    int hold_left  = 0;
    bit hold_done  = 1'b0;
    int stall_mode = 0;
    int mode_left  = 0;

    always #5 aclk = ~aclk;

    video_line_table_scroller_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    video_line_table_scroller_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .error_count  (error_count),
        .result_count (result_count),
        .open_count   (open_count)
    );

    function automatic logic [39:0] pack_word(logic [4:0] first, logic [4:0] last,
                                              logic [7:0] shift, logic [6:0] column,
                                              logic [5:0] line, logic [6:0] row);
        return {2'b00, row, line, column, shift, last, first};
    endfunction

    // offer one word, then keep to the burst pattern
    task automatic offer(vlts_cmd_t cmd, logic [39:0] d);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= cmd;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        words_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 12);
            gap = $urandom_range(0, 8);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (result_count < words_sent)
            @(posedge aclk);
    endtask

    task automatic write_base_page(logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_word();
        logic [39:0] d;
        int pick;
        int first;
        d = {8'(0), $urandom} | (40'($urandom_range(0, 63)) << 32);
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            offer(CMD_RESET, d);
        end else if (pick < 40) begin
            // mostly a window inside the screen, else raw fields for the clamps
            if ($urandom_range(0, 3) != 0) begin
                first = $urandom_range(0, TEXT_LINES_DEF - 1);
                d[4:0] = 5'(first);
                d[9:5] = 5'($urandom_range(first + 1, TEXT_LINES_DEF));
            end
            offer(CMD_SCROLL, d);
        end else if (pick < 70) begin
            if ($urandom_range(0, 3) != 0) begin
                d[24:18] = 7'($urandom_range(0, TEXT_COLUMNS_DEF - 1));
                d[30:25] = 6'($urandom_range(0, TEXT_LINES_DEF - 1));
            end
            offer(CMD_QUERY, d);
        end else begin
            if ($urandom_range(0, 3) != 0)
                d[37:31] = 7'($urandom_range(0, TOTAL_ROWS_DEF - 1));
            offer(CMD_READ, d);
        end
    endtask

    // receiver: changing stall patterns plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                seen_words++;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!hold_done && seen_words >= 300) begin
                hold_done = 1'b1;
                hold_left = 600;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(20, 200);
                end
                mode_left--;
                case (stall_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= $urandom_range(0, 1) == 1;
                    2:       m_tready <= $urandom_range(0, 3) == 0;
                    default: m_tready <= $urandom_range(0, 7) != 0;
                endcase
            end
        end
    end

    initial begin
        logic [7:0] base_value;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: row and query extremes, clamped and empty windows
        offer(CMD_READ,   pack_word(0, 0, 0, 0, 0, 7'd0));
        offer(CMD_READ,   pack_word(0, 0, 0, 0, 0, 7'd119));
        offer(CMD_READ,   pack_word(0, 0, 0, 0, 0, 7'd120));
        offer(CMD_READ,   pack_word(0, 0, 0, 0, 0, 7'd127));
        offer(CMD_QUERY,  pack_word(0, 0, 0, 7'd0, 6'd0, 0));
        offer(CMD_QUERY,  pack_word(0, 0, 0, 7'd25, 6'd14, 0));
        offer(CMD_QUERY,  pack_word(0, 0, 0, 7'd26, 6'd0, 0));
        offer(CMD_QUERY,  pack_word(0, 0, 0, 7'h7F, 6'd0, 0));
        offer(CMD_QUERY,  pack_word(0, 0, 0, 7'd0, 6'd15, 0));
        offer(CMD_QUERY,  pack_word(0, 0, 0, 7'd0, 6'h3F, 0));
        offer(CMD_QUERY,  pack_word(0, 0, 0, 7'h3F, 6'h1F, 0));
        offer(CMD_QUERY,  pack_word(0, 0, 0, 7'h40, 6'h20, 0));
        offer(CMD_SCROLL, pack_word(5'h10, 5'h1F, 8'h7F, 0, 0, 0));
        offer(CMD_READ,   pack_word(0, 0, 0, 0, 0, 7'd8));
        offer(CMD_SCROLL, pack_word(5'd0, 5'd15, 8'h80, 0, 0, 0));
        offer(CMD_QUERY,  pack_word(0, 0, 0, 7'd5, 6'd3, 0));
        offer(CMD_SCROLL, pack_word(5'd10, 5'd5, 8'd3, 0, 0, 0));
        offer(CMD_SCROLL, pack_word(5'd7, 5'd7, 8'd1, 0, 0, 0));
        offer(CMD_SCROLL, pack_word(5'd15, 5'd0, 8'h55, 0, 0, 0));
        offer(CMD_READ,   pack_word(0, 0, 0, 0, 0, 7'd64));
        offer(CMD_RESET,  pack_word(0, 0, 0, 0, 0, 0));
        offer(CMD_READ,   pack_word(0, 0, 0, 0, 0, 7'd100));
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            if (phase == 0)
                base_value = 8'hFF;
            else if (phase == 1)
                base_value = 8'h00;
            else
                base_value = 8'($urandom_range(0, 255));
            write_base_page(base_value);
            offer(CMD_RESET, pack_word(0, 0, 0, 0, 0, 0));
            if (phase == 0)
                offer(CMD_QUERY, pack_word(0, 0, 0, 7'd25, 6'd14, 0));
            repeat (225) random_word();
            drain();
        end

        repeat (20) @(posedge aclk);
        if (error_count == 0 && open_count == 0) begin
            $display("video_line_table_scroller_unit_test passed");
        end else begin
            $display("video_line_table_scroller_unit_test failed");
        end
        $finish;
    end

    initial begin
        #15000000;
        $display("video_line_table_scroller_unit_test failed");
        $finish;
    end

endmodule
